// ===== sv/irfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Inverter reply frame parser package
// Shared types and constants for the reply frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package irfp_pkg;

  localparam int FRAME_DEPTH = 27;
  localparam int LONG_LEN    = 27;
  localparam int SHORT_LEN   = 15;
  localparam int SUM_BYTES   = 14;
  localparam int CRC_AT      = 14;
  localparam int ECHO_AT     = 13;
  localparam int COUNT_MAX   = 31;

  typedef enum logic [1:0] {
    REG_MAGIC    = 2'd0,
    REG_EXPECTED = 2'd1,
    REG_STATUS   = 2'd2,
    REG_SENT     = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HALF,
    PH_BODY
  } phase_t;

  typedef logic [FRAME_DEPTH-1:0][7:0] frame_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] expected_command;
    logic [7:0] status_command;
    logic [7:0] sent_value;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       is_long;
    logic [7:0] sum;
  } pend_t;

endpackage

`default_nettype wire

// ===== sv/irfp_parser.sv =====
// ----------------------------------------------------------------------------
// Reply frame parser byte stage
// Hunts for the header, stores the frame body and flags each finished frame.
// ----------------------------------------------------------------------------
`default_nettype none

module irfp_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire irfp_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     rx_byte,
  input  wire logic           restart,
  input  wire logic           pend_take,
  output irfp_pkg::pend_t     pend,
  output irfp_pkg::frame_t    frame
);
  import irfp_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [4:0] byte_count;
  logic [4:0] byte_count_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [4:0] count_inc;
  logic [4:0] frame_len;
  logic       is_long;
  logic       accept;
  logic       frame_done;
  logic       hdr_we;
  logic       body_we;

  assign in_ready  = !pend.valid || pend_take;
  assign accept    = in_valid && in_ready;
  assign is_long   = (cfg.expected_command == cfg.status_command);
  assign frame_len = is_long ? 5'(LONG_LEN) : 5'(SHORT_LEN);
  assign count_inc = (byte_count < 5'(COUNT_MAX)) ? byte_count + 5'd1 : byte_count;

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    if (accept) begin
      if (restart) begin
        phase_next       = PH_HUNT;
        byte_count_next  = '0;
        running_sum_next = '0;
      end else begin
        case (phase)
          PH_HUNT: begin
            if (rx_byte == cfg.sync_byte) phase_next = PH_HALF;
          end
          PH_HALF: begin
            if (rx_byte == cfg.expected_command) begin
              phase_next       = PH_BODY;
              byte_count_next  = 5'd2;
              running_sum_next = cfg.sync_byte + rx_byte;
            end else if (rx_byte != cfg.sync_byte) begin
              phase_next = PH_HUNT;
            end
          end
          PH_BODY: begin
            if (count_inc >= frame_len) begin
              phase_next       = PH_HUNT;
              byte_count_next  = '0;
              running_sum_next = '0;
            end else begin
              byte_count_next = count_inc;
              if (byte_count < 5'(SUM_BYTES)) running_sum_next = running_sum + rx_byte;
            end
          end
          default: begin
            phase_next = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_comb begin
    hdr_we     = 1'b0;
    body_we    = 1'b0;
    frame_done = 1'b0;
    if (accept && !restart) begin
      case (phase)
        PH_HALF: begin
          hdr_we = (rx_byte == cfg.expected_command);
        end
        PH_BODY: begin
          body_we    = (byte_count < 5'(FRAME_DEPTH));
          frame_done = (count_inc >= frame_len);
        end
        default: begin
          hdr_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      byte_count  <= '0;
      running_sum <= '0;
      pend.valid  <= 1'b0;
    end else begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      if (frame_done) begin
        pend.valid <= 1'b1;
      end else if (pend_take) begin
        pend.valid <= 1'b0;
      end
    end
    if (frame_done) begin
      pend.is_long <= is_long;
      pend.sum     <= running_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      frame[0] <= cfg.sync_byte;
      frame[1] <= rx_byte;
    end
    if (body_we) begin
      frame[byte_count] <= rx_byte;
    end
  end

  a_pend_held: assert property (@(posedge clk) disable iff (rst)
    pend.valid && !pend_take |=> pend.valid)
    else $error("Finished frame was dropped before it reached the result register.");

  a_restart_hunt: assert property (@(posedge clk) disable iff (rst)
    accept && restart |=> phase == PH_HUNT && byte_count == 5'd0 && running_sum == 8'd0)
    else $error("Restart did not return the parser to the header hunt.");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    phase != PH_BODY |-> byte_count == 5'd0)
    else $error("Byte count is nonzero outside the frame body.");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    pend.valid && !pend_take |-> !in_ready)
    else $error("Input taken while a finished frame is still waiting.");

endmodule

`default_nettype wire

// ===== sv/irfp_result.sv =====
// ----------------------------------------------------------------------------
// Reply frame parser result stage
// Decodes a finished frame, forms both power products and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module irfp_result (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire irfp_pkg::cfg_t   cfg,
  input  wire irfp_pkg::pend_t  pend,
  input  wire irfp_pkg::frame_t frame,
  output logic                  pend_take,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  checksum_ok,
  output logic                  value_ok,
  output logic [31:0]           device_id,
  output logic [31:0]           total_energy_bits,
  output logic [15:0]           dc_voltage,
  output logic [15:0]           dc_current,
  output logic [31:0]           dc_power,
  output logic [15:0]           ac_voltage,
  output logic [15:0]           ac_current,
  output logic [31:0]           ac_power,
  output logic [7:0]            state_code,
  output logic [7:0]            temperature
);
  import irfp_pkg::*;

  logic [31:0] energy_d;
  logic [15:0] dv_d;
  logic [15:0] dc_d;
  logic [15:0] av_d;
  logic [15:0] ac_d;
  logic [7:0]  st_d;
  logic [7:0]  tp_d;

  assign pend_take = pend.valid && (!out_valid || out_ready);

  always_comb begin
    energy_d = '0;
    dv_d     = '0;
    dc_d     = '0;
    av_d     = '0;
    ac_d     = '0;
    st_d     = '0;
    tp_d     = '0;
    if (pend.is_long) begin
      energy_d = {frame[10], frame[11], frame[12], frame[13]};
      dv_d     = {frame[15], frame[16]};
      dc_d     = {frame[17], frame[18]};
      av_d     = {frame[19], frame[20]};
      ac_d     = {frame[21], frame[22]};
      st_d     = frame[25];
      tp_d     = frame[26];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_take) begin
      checksum_ok       <= (frame[CRC_AT] == pend.sum);
      value_ok          <= (frame[ECHO_AT] == cfg.sent_value);
      device_id         <= {frame[6], frame[7], frame[8], frame[9]};
      total_energy_bits <= energy_d;
      dc_voltage        <= dv_d;
      dc_current        <= dc_d;
      dc_power          <= 32'(dv_d) * 32'(dc_d);
      ac_voltage        <= av_d;
      ac_current        <= ac_d;
      ac_power          <= 32'(av_d) * 32'(ac_d);
      state_code        <= st_d;
      temperature       <= tp_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/inverter_reply_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// Inverter reply frame parser
// Finds reply frames in a received byte stream and decodes each one.
//
//   Channel  Direction  Handshake             Contents
//   in       input      in_valid / in_ready   rx_byte, restart
//   out      output     out_valid / out_ready checks and decoded fields
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// One byte is taken per cycle while in_ready is high. A finished frame's
// result passes through a pending flag and then the result register.
// Input stalls only while both the pending flag and the result register are
// full and out_ready is low. Reset clears the parser state and both valids;
// the frame store needs no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module inverter_reply_frame_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             checksum_ok,
  output logic             value_ok,
  output logic [31:0]      device_id,
  output logic [31:0]      total_energy_bits,
  output logic [15:0]      dc_voltage,
  output logic [15:0]      dc_current,
  output logic [31:0]      dc_power,
  output logic [15:0]      ac_voltage,
  output logic [15:0]      ac_current,
  output logic [31:0]      ac_power,
  output logic [7:0]       state_code,
  output logic [7:0]       temperature
);
  import irfp_pkg::*;

  cfg_t   cfg;
  pend_t  pend;
  frame_t frame;
  logic   pend_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_MAGIC:    cfg.sync_byte        <= cfg_data;
        REG_EXPECTED: cfg.expected_command <= cfg_data;
        REG_STATUS:   cfg.status_command   <= cfg_data;
        REG_SENT:     cfg.sent_value       <= cfg_data;
        default:      cfg                  <= cfg;
      endcase
    end
  end

  irfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .restart   (restart),
    .pend_take (pend_take),
    .pend      (pend),
    .frame     (frame)
  );

  irfp_result u_result (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .pend              (pend),
    .frame             (frame),
    .pend_take         (pend_take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .checksum_ok       (checksum_ok),
    .value_ok          (value_ok),
    .device_id         (device_id),
    .total_energy_bits (total_energy_bits),
    .dc_voltage        (dc_voltage),
    .dc_current        (dc_current),
    .dc_power          (dc_power),
    .ac_voltage        (ac_voltage),
    .ac_current        (ac_current),
    .ac_power          (ac_power),
    .state_code        (state_code),
    .temperature       (temperature)
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reply frame parser testbench
// Feeds the parser a stream of received bytes under several register
// settings. Most of the stream is well-formed reply frames with random
// content. The rest is noise, restarts, cut-off frames and frames of the
// wrong length. A scoreboard decodes every accepted byte the way the parser
// should. It then compares each result transaction, field by field, with
// the oldest decoded frame.
// ----------------------------------------------------------------------------

module testbench;
  import irfp_pkg::*;

  localparam int NUM_SETTINGS      = 9;
  localparam int ITEMS_PER_SETTING = 205;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int SETTLE_CYCLES     = 6;

  typedef struct packed {
    logic        checksum_ok;
    logic        value_ok;
    logic [31:0] device_id;
    logic [31:0] total_energy_bits;
    logic [15:0] dc_voltage;
    logic [15:0] dc_current;
    logic [31:0] dc_power;
    logic [15:0] ac_voltage;
    logic [15:0] ac_current;
    logic [31:0] ac_power;
    logic [7:0]  state_code;
    logic [7:0]  temperature;
  } reply_t;

  class reply_scoreboard;
    cfg_t       regs;
    phase_t     hunt;
    logic [4:0] count;
    logic [7:0] sum;
    logic [7:0] frame [FRAME_DEPTH];
    reply_t     decoded_frames[$];
    int         mismatches;

    function new();
      regs = '0;
      hunt = PH_HUNT;
      count = '0;
      sum = '0;
      foreach (frame[i]) frame[i] = 8'h00;
      mismatches = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [7:0] val);
      case (idx)
        REG_MAGIC:    regs.sync_byte = val;
        REG_EXPECTED: regs.expected_command = val;
        REG_STATUS:   regs.status_command = val;
        REG_SENT:     regs.sent_value = val;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic rs);
      reply_t r;
      logic   is_long;
      int     len;
      if (rs) begin
        hunt = PH_HUNT;
        count = '0;
        sum = '0;
        return;
      end
      case (hunt)
        PH_HUNT: begin
          if (b == regs.sync_byte) hunt = PH_HALF;
        end
        PH_HALF: begin
          if (b == regs.expected_command) begin
            frame[0] = regs.sync_byte;
            frame[1] = b;
            sum = regs.sync_byte + b;
            count = 5'd2;
            hunt = PH_BODY;
          end else if (b != regs.sync_byte) begin
            hunt = PH_HUNT;
          end
        end
        default: begin
          if (count < LONG_LEN) frame[count] = b;
          if (count < SUM_BYTES) sum = sum + b;
          if (count < COUNT_MAX) count = count + 5'd1;
          is_long = (regs.expected_command == regs.status_command);
          len = is_long ? LONG_LEN : SHORT_LEN;
          if (count >= len) begin
            r = '0;
            r.checksum_ok = (frame[CRC_AT] == sum);
            r.value_ok = (frame[ECHO_AT] == regs.sent_value);
            r.device_id = {frame[6], frame[7], frame[8], frame[9]};
            if (is_long) begin
              r.total_energy_bits = {frame[10], frame[11], frame[12], frame[13]};
              r.dc_voltage = {frame[15], frame[16]};
              r.dc_current = {frame[17], frame[18]};
              r.ac_voltage = {frame[19], frame[20]};
              r.ac_current = {frame[21], frame[22]};
              r.state_code = frame[25];
              r.temperature = frame[26];
            end
            r.dc_power = 32'(r.dc_voltage) * 32'(r.dc_current);
            r.ac_power = 32'(r.ac_voltage) * 32'(r.ac_current);
            decoded_frames.push_back(r);
            hunt = PH_HUNT;
            count = '0;
            sum = '0;
          end
        end
      endcase
    endfunction

    function void field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%s mismatch: expected %0h, actual %0h", name, want, got);
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (decoded_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result with no frame pending: actual %h", got);
        return;
      end
      want = decoded_frames.pop_front();
      field("checksum_ok", want.checksum_ok, got.checksum_ok);
      field("value_ok", want.value_ok, got.value_ok);
      field("device_id", want.device_id, got.device_id);
      field("total_energy_bits", want.total_energy_bits, got.total_energy_bits);
      field("dc_voltage", want.dc_voltage, got.dc_voltage);
      field("dc_current", want.dc_current, got.dc_current);
      field("dc_power", want.dc_power, got.dc_power);
      field("ac_voltage", want.ac_voltage, got.ac_voltage);
      field("ac_current", want.ac_current, got.ac_current);
      field("ac_power", want.ac_power, got.ac_power);
      field("state_code", want.state_code, got.state_code);
      field("temperature", want.temperature, got.temperature);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  reg_index_t  cfg_index = REG_MAGIC;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        checksum_ok;
  logic        value_ok;
  logic [31:0] device_id;
  logic [31:0] total_energy_bits;
  logic [15:0] dc_voltage;
  logic [15:0] dc_current;
  logic [31:0] dc_power;
  logic [15:0] ac_voltage;
  logic [15:0] ac_current;
  logic [31:0] ac_power;
  logic [7:0]  state_code;
  logic [7:0]  temperature;

  reply_scoreboard replies;
  cfg_t            setting;
  int              send_idle;
  int              recv_idle;
  int              items_sent;
  int              cycles;

  inverter_reply_frame_parser_top dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .restart           (restart),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .checksum_ok       (checksum_ok),
    .value_ok          (value_ok),
    .device_id         (device_id),
    .total_energy_bits (total_energy_bits),
    .dc_voltage        (dc_voltage),
    .dc_current        (dc_current),
    .dc_power          (dc_power),
    .ac_voltage        (ac_voltage),
    .ac_current        (ac_current),
    .ac_power          (ac_power),
    .state_code        (state_code),
    .temperature       (temperature)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every result transaction is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        replies.check_reply({checksum_ok, value_ok, device_id, total_energy_bits,
                             dc_voltage, dc_current, dc_power, ac_voltage,
                             ac_current, ac_power, state_code, temperature});
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(logic [7:0] b, logic rs);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    restart <= rs;
    do @(posedge clk); while (!in_ready);
    replies.take_byte(b, rs);
    if (!rs) items_sent++;
  endtask

  task automatic apply_setting(cfg_t s);
    reg_index_t idx;
    logic [7:0] val;
    idx = idx.first();
    cfg_write <= 1'b1;
    do begin
      case (idx)
        REG_MAGIC:    val = s.sync_byte;
        REG_EXPECTED: val = s.expected_command;
        REG_STATUS:   val = s.status_command;
        default:      val = s.sent_value;
      endcase
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      replies.write_reg(idx, val);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_write <= 1'b0;
    setting = s;
  endtask

  // Sends the first cut bytes of a frame of frame_len bytes, after
  // extra_magic repeated sync bytes. A negative fill gives random content.
  task automatic send_frame(int frame_len, int cut, bit good_sum, bit good_echo,
                            int extra_magic, int fill);
    logic [7:0] f [LONG_LEN];
    logic [7:0] total;
    f[0] = setting.sync_byte;
    f[1] = setting.expected_command;
    for (int i = 2; i < LONG_LEN; i++) f[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    if (good_echo) f[ECHO_AT] = setting.sent_value;
    total = 8'h00;
    for (int i = 0; i < SUM_BYTES; i++) total = total + f[i];
    f[CRC_AT] = good_sum ? total : total + 8'($urandom_range(1, 255));
    repeat (extra_magic) send_item(setting.sync_byte, 1'b0);
    for (int i = 0; i < cut && i < frame_len; i++) send_item(f[i], 1'b0);
  endtask

  task automatic random_burst();
    int kind;
    int flen;
    kind = $urandom_range(99);
    flen = (setting.expected_command == setting.status_command) ? LONG_LEN : SHORT_LEN;
    if (kind < 60) begin
      if ($urandom_range(1)) send_item(8'($urandom), 1'b1);
      send_frame(flen, flen, $urandom_range(99) < 80, $urandom_range(99) < 70,
                 ($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0, -1);
    end else if (kind < 70) begin
      send_frame(LONG_LEN + SHORT_LEN - flen, LONG_LEN + SHORT_LEN - flen,
                 $urandom_range(1), $urandom_range(1), 0, -1);
    end else if (kind < 80) begin
      send_frame(flen, $urandom_range(1, flen - 1), 1'b1, 1'b1, 0, -1);
      send_item(8'($urandom), 1'b1);
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 8)) send_item(8'($urandom), $urandom_range(99) < 10);
    end else begin
      send_item(setting.sync_byte, 1'b0);
      send_item(8'($urandom), 1'b0);
    end
  endtask

  task automatic settle();
    while (replies.decoded_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic cfg_t pick_setting(int p);
    cfg_t s;
    s.sync_byte = 8'($urandom);
    s.expected_command = 8'($urandom);
    s.status_command = $urandom_range(1) ? s.expected_command : 8'($urandom);
    s.sent_value = 8'($urandom);
    case (p)
      0: s = {8'hAA, 8'h55, 8'h11, 8'hFF};
      1: s = {8'hA5, 8'h06, 8'h06, 8'h3C};
      2: s = {8'h00, 8'hFF, 8'h00, 8'hFF};
      3: s = {8'hFF, 8'h00, 8'h00, 8'h00};
      4: s = {8'h7E, 8'h7E, 8'h11, 8'h80};
      5: s = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    replies = new();
    setting = '0;
    send_idle = 28;
    recv_idle = 62;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      send_idle = (p < 3) ? 28 : (p < 6) ? 62 : 0;
      recv_idle = (p < 3) ? 62 : (p < 6) ? 28 : 0;
      apply_setting(pick_setting(p));
      if (p == 0) begin
        send_item(setting.sync_byte, 1'b1);
        send_item(8'h00, 1'b0);
        send_frame(SHORT_LEN, SHORT_LEN, 1'b1, 1'b1, 2, 255);
        send_item(setting.sync_byte, 1'b0);
        send_item(8'h00, 1'b0);
        send_frame(SHORT_LEN, 4, 1'b1, 1'b1, 0, 0);
        send_item(8'hFF, 1'b1);
      end
      while (items_sent < (p + 1) * ITEMS_PER_SETTING) random_burst();
      // Leaving a frame open lets the next setting change its length mid-frame.
      if ($urandom_range(1)) send_frame(LONG_LEN, $urandom_range(3, 14), 1'b1, 1'b1, 0, -1);
      in_valid <= 1'b0;
      settle();
    end
    settle();
    if (replies.mismatches == 0 && replies.decoded_frames.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/irfp_pkg.sv
sv/irfp_parser.sv
sv/irfp_result.sv
sv/inverter_reply_frame_parser_top.sv
dv/testbench.sv
